[rtl/pte_pkg.sv]
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types, codes and helpers of the periodic time event table.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_MAX_W    = 6;   // enough for the largest slot count

    localparam logic [63:0] DUE_NEVER = 64'h7FFF_FFFF_FFFF_FFFF;

    // request type codes on the input channel
    localparam logic [1:0] REQ_ONCE     = 2'd0;
    localparam logic [1:0] REQ_PERIODIC = 2'd1;
    localparam logic [1:0] REQ_TIME     = 2'd2;

    // classified operation codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ONCE = 2'd1;
    localparam logic [1:0] OP_PER  = 2'd2;
    localparam logic [1:0] OP_TIME = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [SLOT_MAX_W-1:0] slot;
        logic [63:0]           tv;
        logic [62:0]           per;
    } req_t;

    function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // base plus offset, saturated at end of time
    function automatic logic [63:0] add_sat(input logic [63:0] base,
                                            input logic [62:0] off);
        logic [63:0] room;
        room = DUE_NEVER - base;
        if ({1'b0, off} > room)
            return DUE_NEVER;
        return base + {1'b0, off};
    endfunction

endpackage

[rtl/periodic_time_event_table_top.sv]
// ----------------------------------------------------------------------------
// periodic_time_event_table_top
// Table of event slots with one-shot and periodic reload, driven by time beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests: tuser selects one-shot activate, periodic
//   activate or time propagate; tdata holds slot, time value and period.
//   m_ channel returns one beat per request: fired mask, fired count and the
//   earliest due time over all slots after the request.
// Request flow:
//   Each request walks every slot once through the slot table: read,
//   evaluate and write back; a fired periodic slot adds a reload and a
//   check, and a late one also waits on the bit-serial remainder unit.
//   The back end takes the next request only once its result is stored.
// Reset: all slots read as end of time with zero period; queue and result
//   register are emptied.
// Stall: a two-entry queue keeps taking requests while a result waits in the
//   output register; the back end holds once the result register is full.
// ----------------------------------------------------------------------------
module periodic_time_event_table_top #(
    parameter int NUM_SLOTS = pte_pkg::NUM_SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,   // req_type
    input  logic [135:0]  s_tdata,   // slot[3:0], time_value[67:4], period[130:68]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [87:0]   m_tdata    // fired_mask[15:0], fired_count[20:16],
                                     // next_trigger[84:21]
);
    import pte_pkg::*;

    logic        q_valid;
    logic        q_pop;
    req_t        q_req;
    logic [15:0] mask;
    logic [4:0]  count;
    logic [63:0] next_trigger;

    pte_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_slot   (s_tdata[3:0]),
        .s_tv     (s_tdata[67:4]),
        .s_per    (s_tdata[130:68]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    pte_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_mask   (mask),
        .m_count  (count),
        .m_next   (next_trigger)
    );

    assign m_tdata = {3'd0, next_trigger, count, mask};

endmodule

[rtl/pte_front.sv]
// ----------------------------------------------------------------------------
// pte_front
// Accepts request beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pte_front #(
    parameter int NUM_SLOTS = pte_pkg::NUM_SLOTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      s_tuser,
    input  logic [3:0]      s_slot,
    input  logic [63:0]     s_tv,
    input  logic [62:0]     s_per,
    output logic            q_valid,
    input  logic            q_pop,
    output pte_pkg::req_t   q_req
);
    import pte_pkg::*;

    req_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       cls;
    logic       push, pop;
    logic [7:0] slot8;

    assign slot8 = {4'd0, s_slot};

    always_comb begin
        cls.slot = slot8[SLOT_MAX_W-1:0];
        cls.tv   = s_tv;
        cls.per  = s_per;
        cls.op   = OP_NONE;
        case (s_tuser)
            REQ_ONCE:     cls.op = (slot8 < 8'(NUM_SLOTS)) ? OP_ONCE : OP_NONE;
            REQ_PERIODIC: cls.op = (slot8 < 8'(NUM_SLOTS)) ? OP_PER : OP_NONE;
            REQ_TIME:     cls.op = OP_TIME;
            default:      cls.op = OP_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

endmodule

[rtl/pte_div.sv]
// ----------------------------------------------------------------------------
// pte_div
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pte_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [62:0] divisor,
    output logic        done,
    output logic [62:0] remainder
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [62:0] rem_reg, rem_next;
    logic [62:0] dvs_reg, dvs_next;
    logic [63:0] shifted;
    logic [63:0] diff;

    assign shifted   = {rem_reg, quo_reg[63]};
    assign diff      = shifted - {1'b0, dvs_reg};
    assign remainder = rem_reg;
    assign done      = busy_reg && (cnt_reg == 7'd63);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            quo_next  = dividend;
            rem_next  = 63'd0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], 1'b0};
            // remainder stays below the divisor, so it fits 63 bits
            rem_next = (shifted >= {1'b0, dvs_reg}) ? diff[62:0] : shifted[62:0];
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

[rtl/pte_back.sv]
// ----------------------------------------------------------------------------
// pte_back
// Executes queued requests: slot writes, the time walk with reload, and the
// earliest due time scan. Holds the slot table and the result register.
// ----------------------------------------------------------------------------
module pte_back #(
    parameter int NUM_SLOTS = pte_pkg::NUM_SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_pop,
    input  pte_pkg::req_t q_req,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_mask,
    output logic [4:0]    m_count,
    output logic [63:0]   m_next
);
    import pte_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WR   = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_ADD  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [63:0] due_mem [NUM_SLOTS];
    logic [62:0] per_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;
    logic [63:0]       tv_reg, tv_next;
    logic [62:0]       per_reg, per_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [63:0]       dcur_reg, dcur_next;
    logic [62:0]       pcur_reg, pcur_next;
    logic [63:0]       dnew_reg, dnew_next;
    logic              fire_reg, fire_next;
    logic [15:0]       mask_reg, mask_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [63:0]       min_reg, min_next;
    logic [63:0]       rd_due_reg;
    logic [62:0]       rd_per_reg;
    logic              rd_vld_reg;
    logic              out_vld_reg, out_vld_next;
    logic [15:0]       out_mask_reg, out_mask_next;
    logic [4:0]        out_cnt_reg, out_cnt_next;
    logic [63:0]       out_next_reg, out_next_next;

    logic              div_start;
    logic              div_done;
    logic [62:0]       div_rem;
    logic [63:0]       d_eff;
    logic [62:0]       p_eff;
    logic [SLOT_W-1:0] walk_addr;
    logic [7:0]        idx8;

    assign walk_addr = idx_reg[SLOT_W-1:0];
    assign idx8      = 8'(idx_reg);
    assign d_eff     = rd_vld_reg ? rd_due_reg : DUE_NEVER;
    assign p_eff     = rd_vld_reg ? rd_per_reg : 63'd0;

    pte_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (tv_reg - dnew_reg),
        .divisor   (pcur_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        tv_next       = tv_reg;
        per_next      = per_reg;
        idx_next      = idx_reg;
        dcur_next     = dcur_reg;
        pcur_next     = pcur_reg;
        dnew_next     = dnew_reg;
        fire_next     = fire_reg;
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        min_next      = min_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_mask_next = out_mask_reg;
        out_cnt_next  = out_cnt_reg;
        out_next_next = out_next_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    op_next   = q_req.op;
                    addr_next = q_req.slot[SLOT_W-1:0];
                    tv_next   = q_req.tv;
                    per_next  = (q_req.op == OP_PER) ? q_req.per : 63'd0;
                    idx_next  = '0;
                    mask_next = 16'd0;
                    cnt_next  = 5'd0;
                    min_next  = DUE_NEVER;
                    state_next = (q_req.op == OP_ONCE || q_req.op == OP_PER) ? S_WR : S_RD;
                end
            end
            S_WR: state_next = S_RD;
            S_RD: state_next = S_EV;
            S_EV: begin
                dcur_next = d_eff;
                pcur_next = p_eff;
                dnew_next = d_eff;
                fire_next = 1'b0;
                state_next = S_WB;
                if (op_reg == OP_TIME && slt(d_eff, tv_reg)) begin
                    fire_next = 1'b1;
                    if (p_eff == 63'd0)
                        dnew_next = DUE_NEVER;
                    else
                        state_next = S_ADD;
                end
            end
            S_ADD: begin
                dnew_next  = add_sat(dcur_reg, pcur_reg);
                state_next = S_CHK;
            end
            S_CHK: begin
                // still in the past: jump to the first beat after now
                if (slt(dnew_reg, tv_reg)) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_WB;
                end
            end
            S_DIV: begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN: begin
                dnew_next  = add_sat(tv_reg, pcur_reg - div_rem);
                state_next = S_WB;
            end
            S_WB: begin
                if (fire_reg) begin
                    if (idx8 < 8'd16)
                        mask_next[idx8[3:0]] = 1'b1;
                    if (cnt_reg != 5'd31)
                        cnt_next = cnt_reg + 5'd1;
                end
                if (slt(dnew_reg, min_reg))
                    min_next = dnew_reg;
                if (idx_reg == CNT_W'(NUM_SLOTS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next  = 1'b1;
                    out_mask_next = mask_reg;
                    out_cnt_next  = cnt_reg;
                    out_next_next = min_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            if (state_reg == S_WR)
                vld_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        tv_reg       <= tv_next;
        per_reg      <= per_next;
        idx_reg      <= idx_next;
        dcur_reg     <= dcur_next;
        pcur_reg     <= pcur_next;
        dnew_reg     <= dnew_next;
        fire_reg     <= fire_next;
        mask_reg     <= mask_next;
        cnt_reg      <= cnt_next;
        min_reg      <= min_next;
        out_mask_reg <= out_mask_next;
        out_cnt_reg  <= out_cnt_next;
        out_next_reg <= out_next_next;
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == S_WR) begin
            due_mem[addr_reg] <= tv_reg;
            per_mem[addr_reg] <= per_reg;
        end else if (state_reg == S_WB && fire_reg) begin
            due_mem[walk_addr] <= dnew_reg;
        end
        rd_due_reg <= due_mem[walk_addr];
        rd_per_reg <= per_mem[walk_addr];
        rd_vld_reg <= vld_reg[walk_addr];
    end

    assign m_tvalid = out_vld_reg;
    assign m_mask   = out_mask_reg;
    assign m_count  = out_cnt_reg;
    assign m_next   = out_next_reg;

endmodule

[tb/sv/periodic_time_event_table_top_tb.sv]
// ----------------------------------------------------------------------------
// periodic_time_event_table_top_tb
// Self-checking bench for the periodic time event table: a directed table of
// requests, then random activate/propagate traffic with random stalls on both
// channels; beats checked against given values or a cycle-free table predictor.
// ----------------------------------------------------------------------------
module periodic_time_event_table_top_tb;

    import pte_pkg::*;

    localparam int          SLOTS      = 16;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [63:0] TIME_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [62:0] PER_MAX    = {63{1'b1}};
    localparam int          DRAIN_CYC  = 1200;

    typedef struct packed {
        logic [15:0] mask;
        logic [4:0]  count;
        logic [63:0] next;
    } fire_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [63:0] tv;
        logic [62:0] per;
        bit          has_exp;
        fire_t       exp;
    } req_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [1:0]    s_tuser = '0;
    logic [135:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [87:0]   m_tdata;

    logic [63:0]   slot_due [SLOTS];
    logic [62:0]   slot_per [SLOTS];
    fire_t         pending_fires [$];
    req_row_t      dir_rows [$];
    int            errors = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    logic [63:0]   now_t;

    periodic_time_event_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #500_000_000;
        $display("periodic_time_event_table_top_tb: errors");
        $finish;
    end

    function automatic logic [63:0] sat_add(input logic [63:0] base,
                                            input logic [62:0] off);
        logic [63:0] room;
        room = DUE_NEVER - base;
        if ({1'b0, off} > room) return DUE_NEVER;
        return base + {1'b0, off};
    endfunction

    // Apply one request to the table copy and return the fire report.
    function automatic fire_t fire_table(input logic [1:0] kind, input logic [3:0] slot,
                                         input logic [63:0] tv, input logic [62:0] per);
        fire_t       res;
        logic [63:0] d;
        logic [63:0] rem;
        res = '{mask: '0, count: '0, next: DUE_NEVER};
        if (kind == REQ_ONCE || kind == REQ_PERIODIC) begin
            slot_due[slot] = tv;
            slot_per[slot] = (kind == REQ_PERIODIC) ? per : '0;
        end else if (kind == REQ_TIME) begin
            for (int i = 0; i < SLOTS; i++) begin
                d = slot_due[i];
                if ($signed(d) < $signed(tv)) begin
                    if (slot_per[i] == '0) begin
                        d = DUE_NEVER;
                    end else begin
                        d = sat_add(d, slot_per[i]);
                        // still late: jump to the first beat after now
                        if ($signed(d) < $signed(tv)) begin
                            rem = (tv - d) % {1'b0, slot_per[i]};
                            d = sat_add(tv, slot_per[i] - rem[62:0]);
                        end
                    end
                    slot_due[i] = d;
                    res.mask[i] = 1'b1;
                    res.count = res.count + 1'b1;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if ($signed(slot_due[i]) < $signed(res.next)) res.next = slot_due[i];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic [3:0] slot,
                                    input logic [63:0] tv, input logic [62:0] per,
                                    input bit has_exp, input fire_t exp);
        req_row_t row;
        row.kind = kind; row.slot = slot; row.tv = tv; row.per = per;
        row.has_exp = has_exp; row.exp = exp;
        dir_rows.push_back(row);
    endfunction

    task automatic send_req(input req_row_t row);
        fire_t pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.kind;
        s_tdata  <= {5'b0, row.per, row.tv, row.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = fire_table(row.kind, row.slot, row.tv, row.per);
        pending_fires.push_back(row.has_exp ? row.exp : pred);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_fires.size() != 0) @(posedge aclk);
    endtask

    function automatic req_row_t random_req();
        req_row_t row;
        int       pick;
        pick = $urandom_range(0, 99);
        row.has_exp = 1'b0;
        row.exp = '0;
        row.slot = 4'($urandom_range(0, 15));
        row.per = '0;
        if (pick < 35) begin
            row.kind = REQ_PERIODIC;
            row.tv = now_t + $urandom_range(0, 300) - 64'd60;
            row.per = ($urandom_range(0, 9) == 0) ? 63'(rand64())
                                                  : 63'($urandom_range(1, 250));
        end else if (pick < 55) begin
            row.kind = REQ_ONCE;
            row.tv = now_t + $urandom_range(0, 500) - 64'd40;
            row.per = 63'(rand64());
        end else if (pick < 90) begin
            row.kind = REQ_TIME;
            now_t = now_t + $urandom_range(0, 400);
            row.tv = now_t;
        end else begin
            // noise: any code, any field value
            row.kind = 2'($urandom_range(0, 3));
            row.tv = rand64();
            row.per = 63'(rand64());
        end
        return row;
    endfunction

    // Check result beats in order and pick the stall for the next cycle.
    always @(posedge aclk) begin
        fire_t got;
        fire_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.mask  = m_tdata[15:0];
            got.count = m_tdata[20:16];
            got.next  = m_tdata[84:21];
            if (pending_fires.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
            end else begin
                want = pending_fires.pop_front();
                if (got.mask !== want.mask) begin
                    $error("fired_mask expected %h got %h", want.mask, got.mask);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("fired_count expected %0d got %0d", want.count, got.count);
                    errors++;
                end
                if (got.next !== want.next) begin
                    $error("next_trigger expected %h got %h", want.next, got.next);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_due[i] = DUE_NEVER;
            slot_per[i] = '0;
        end
        now_t = 64'd1000;

        add_row(REQ_TIME,     4'd0,  64'd0,         '0,      1'b1, '{16'h0, 5'd0, DUE_NEVER});
        add_row(REQ_ONCE,     4'd0,  TIME_MIN,      PER_MAX, 1'b1, '{16'h0, 5'd0, TIME_MIN});
        add_row(REQ_TIME,     4'd0,  TIME_MIN,      '0,      1'b1, '{16'h0, 5'd0, TIME_MIN});
        add_row(REQ_TIME,     4'd0,  TIME_MIN + 1,  '0,      1'b1, '{16'h1, 5'd1, DUE_NEVER});
        add_row(REQ_PERIODIC, 4'd15, 64'd100,       PER_MAX, 1'b0, '0);
        // reload overflows and saturates
        add_row(REQ_TIME,     4'd0,  DUE_NEVER,     '0,      1'b1,
                '{16'h8000, 5'd1, DUE_NEVER});
        add_row(REQ_UNUSED,   4'd7,  64'd5,         PER_MAX, 1'b1, '{16'h0, 5'd0, DUE_NEVER});
        add_row(REQ_PERIODIC, 4'd3,  64'd0,         63'd10,  1'b0, '0);
        add_row(REQ_TIME,     4'd0,  64'd35,        '0,      1'b0, '0);
        add_row(REQ_PERIODIC, 4'd4,  -64'sd5,       63'd1,   1'b0, '0);
        add_row(REQ_PERIODIC, 4'd13, 64'd7,         63'd0,   1'b0, '0);
        add_row(REQ_TIME,     4'd0,  64'd1000,      '0,      1'b0, '0);
        for (int i = 0; i < SLOTS; i++)
            add_row(i[0] ? REQ_PERIODIC : REQ_ONCE, i[3:0], -64'sd3 * i, 63'd7, 1'b0, '0);
        add_row(REQ_TIME,     4'd0,  64'd50,        '0,      1'b0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 12 : 0;
            if (ph == 0)
                foreach (dir_rows[k]) send_req(dir_rows[k]);
            for (int n = 0; n < 660; n++) begin
                send_req(random_req());
                // hold off now and then until the table has answered everything
                if (n % 200 == 199) wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0)
            $display("periodic_time_event_table_top_tb: clean");
        else
            $display("periodic_time_event_table_top_tb: errors");
        $finish;
    end

endmodule

[files.f]
rtl/pte_pkg.sv
rtl/pte_front.sv
rtl/pte_div.sv
rtl/pte_back.sv
rtl/periodic_time_event_table_top.sv
tb/sv/periodic_time_event_table_top_tb.sv
